// ===== sv/obphs_pkg.sv =====
// ----------------------------------------------------------------------------
// Oriented box point hit scan package
// Shared types, command codes and constants for the box hit scan block.
// ----------------------------------------------------------------------------
package obphs_pkg;

    localparam int MaxBoxes  = 16;
    localparam int BoxWords  = 18;
    localparam int MemDepth  = MaxBoxes * BoxWords;
    localparam int AddrW     = $clog2(MemDepth);
    localparam int BoxW      = $clog2(MaxBoxes);
    localparam int CountW    = $clog2(MaxBoxes + 1);
    localparam int WordIdxW  = 5;

    // determinant magnitude at or below this counts as singular (2^-48 units)
    localparam logic [159:0] DetEps = 160'd2814749;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENABLE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // datapath micro-operation, issued one per cycle by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_READ,       // read word at rd_word into word register file
        OP_BROAD,      // broad phase distance check
        OP_MUL_A,      // product 1 of a cofactor/determinant term
        OP_MUL_B,      // product 2 and subtract -> cofactor
        OP_DOT_MUL,    // one wide multiply step of a dot product
        OP_DOT_ADD,    // accumulate
        OP_DET_DONE,   // absolute determinant and singular check
        OP_CMP_MUL,    // rhs products, one limb of |D| each
        OP_CMP_TEST    // compare and record miss
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [4:0]       word;    // word to read / cofactor index / step index
        logic [1:0]       row;     // axis or row selector
        logic             clear;   // clear accumulator
    } dp_cmd_t;

    typedef struct packed {
        logic broad_miss;
        logic singular;
        logic cmp_miss;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NEXT,
        ST_READ,
        ST_BROAD,
        ST_COF,
        ST_DET,
        ST_ROW,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

// ===== sv/obphs_datapath.sv =====
// ----------------------------------------------------------------------------
// Oriented box point hit scan datapath
// Box word memory, word registers, a 32x32 cofactor multiplier, a dot product
// multiply built from 32x34 partial products, a compare multiplier and the wide accumulator for the containment test.
// ----------------------------------------------------------------------------
module obphs_datapath
    import obphs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // memory write port
    input  logic                wr_en,
    input  logic [AddrW-1:0]    wr_addr,
    input  logic signed [31:0]  wr_data,
    // read address
    input  logic [BoxW-1:0]     rd_box,
    // query point load
    input  logic                pt_load,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat
);

    // ---------------------------------------------------------------- memory
    logic signed [31:0] mem [MemDepth];
    logic signed [31:0] rd_data_reg;
    logic [AddrW-1:0]   rd_addr;
    logic [4:0]         rd_word_reg;
    logic               rd_valid_reg;

    assign rd_addr = AddrW'(rd_box * BoxWords) + AddrW'(cmd.word);

    // write loads, read registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_word_reg  <= '0;
        end
        else
        begin
            rd_valid_reg <= (cmd.op == OP_READ);
            rd_word_reg  <= cmd.word;
        end
    end

    // capture words of the current box
    logic signed [31:0] w_reg [BoxWords];
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            w_reg[rd_word_reg] <= rd_data_reg;
        end
    end

    // hold query point
    logic signed [31:0] p_reg [3];
    always_ff @(posedge clk)
    begin
        if (pt_load)
        begin
            p_reg[0] <= point_x;
            p_reg[1] <= point_y;
            p_reg[2] <= point_z;
        end
    end

    // ---------------------------------------------------------------- broad
    logic signed [31:0] mn;
    logic signed [33:0] lim;
    logic signed [32:0] pt_dist;
    logic        [32:0] adist;
    logic [1:0]         ax;

    assign ax = cmd.row;
    always_comb
    begin
        mn = w_reg[12];
        if (w_reg[13] < mn) mn = w_reg[13];
        if (w_reg[14] < mn) mn = w_reg[14];
        lim     = 34'(mn) <<< 1;
        pt_dist = 33'(p_reg[ax]) - 33'(w_reg[5'd15 + 5'(ax)]);
        adist   = pt_dist[32] ? 33'(-pt_dist) : 33'(pt_dist);
    end

    // ------------------------------------------------------ cofactor operands
    // cofactor k = a[i0]*a[i1] - a[i2]*a[i3]
    logic [3:0] ci [4];
    always_comb
    begin
        case (cmd.word[3:0])
            4'd0:    begin ci[0]=4'd4; ci[1]=4'd8; ci[2]=4'd5; ci[3]=4'd7; end
            4'd1:    begin ci[0]=4'd2; ci[1]=4'd7; ci[2]=4'd1; ci[3]=4'd8; end
            4'd2:    begin ci[0]=4'd1; ci[1]=4'd5; ci[2]=4'd2; ci[3]=4'd4; end
            4'd3:    begin ci[0]=4'd5; ci[1]=4'd6; ci[2]=4'd3; ci[3]=4'd8; end
            4'd4:    begin ci[0]=4'd0; ci[1]=4'd8; ci[2]=4'd2; ci[3]=4'd6; end
            4'd5:    begin ci[0]=4'd2; ci[1]=4'd3; ci[2]=4'd0; ci[3]=4'd5; end
            4'd6:    begin ci[0]=4'd3; ci[1]=4'd7; ci[2]=4'd4; ci[3]=4'd6; end
            4'd7:    begin ci[0]=4'd1; ci[1]=4'd6; ci[2]=4'd0; ci[3]=4'd7; end
            4'd8:    begin ci[0]=4'd0; ci[1]=4'd4; ci[2]=4'd1; ci[3]=4'd3; end
            default: begin ci[0]=4'd0; ci[1]=4'd0; ci[2]=4'd0; ci[3]=4'd0; end
        endcase
    end

    logic signed [63:0] k_reg [9];
    logic signed [63:0] prod_a_reg;
    logic signed [63:0] mul32;
    logic signed [31:0] ma, mb;

    // ---------------------------------------------------------- dot product
    // term: 64-bit signed x (33-bit v or 32-bit a) product, built from
    // two 32x34 partial products, low half first, the low one held in a 97-bit register.
    logic signed [63:0] dk;
    logic signed [33:0] dv;
    logic               phase_reg;
    logic signed [66:0] pp;
    logic signed [96:0] term_lo_reg;
    logic signed [159:0] acc_reg;
    logic        [159:0] adet_reg;

    logic [3:0]  kidx;
    logic [1:0]  j;
    assign j = cmd.word[1:0];

    always_comb
    begin
        // determinant row: a[j] * k[3j]; adjugate row i: k[3i+j] * v[j]
        if (cmd.row == 2'd3)
        begin
            kidx = 4'(3 * j);
            dv   = 34'(w_reg[j]);
        end
        else
        begin
            kidx = 4'(3 * cmd.row + j);
            dv   = 34'(p_reg[j]) - 34'(w_reg[5'd9 + 5'(j)]);
        end
        dk = k_reg[kidx];
    end

    // one 32x34 partial multiply, low or high half of dk
    always_comb
    begin
        if (!phase_reg)
            pp = $signed({1'b0, dk[31:0]}) * dv;
        else
            pp = $signed(dk[63:32]) * dv;
    end

    always_comb
    begin
        ma = 32'(0);
        mb = 32'(0);
        if (cmd.op == OP_MUL_A)
        begin
            ma = w_reg[ci[0]];
            mb = w_reg[ci[1]];
        end
        else
        begin
            ma = w_reg[ci[2]];
            mb = w_reg[ci[3]];
        end
        mul32 = 64'(ma) * 64'(mb);
    end

    // ------------------------------------------------------------- compare
    // lhs = 2^17 * |N|, rhs = |S| * |D|: |D| split into 32-bit limbs
    logic        [159:0] an;
    logic        [32:0]  asz;
    logic        [2:0]   limb;
    logic        [64:0]  rp;
    logic        [191:0] rhs_reg;
    logic signed [32:0]  sz;

    assign an   = acc_reg[159] ? 160'(-acc_reg) : acc_reg;
    assign limb = cmd.word[2:0];
    assign sz   = 33'(w_reg[5'd12 + 5'(cmd.row)]);
    assign asz  = sz[32] ? 33'(-sz) : 33'(sz);
    assign rp   = 65'(asz) * 65'(adet_reg[32*limb +: 32]);

    logic broad_miss_reg, singular_reg, cmp_miss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 1'b0;
            broad_miss_reg <= 1'b0;
            singular_reg   <= 1'b0;
            cmp_miss_reg   <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_BROAD:
                begin
                    if (lim[33] || (34'(adist) > lim))
                        broad_miss_reg <= 1'b1;
                    else if (cmd.clear)
                        broad_miss_reg <= 1'b0;
                end
                OP_DOT_MUL: phase_reg <= ~phase_reg;
                OP_DET_DONE:
                begin
                    singular_reg <= (an <= DetEps);
                    cmp_miss_reg <= 1'b0;
                end
                OP_CMP_TEST:
                begin
                    if ({15'd0, an, 17'd0} > rhs_reg)
                        cmp_miss_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MUL_A: prod_a_reg <= mul32;
            OP_MUL_B: k_reg[cmd.word[3:0]] <= prod_a_reg - mul32;
            OP_DOT_MUL:
            begin
                if (!phase_reg)
                    term_lo_reg <= 97'(pp);
                else
                    acc_reg <= (cmd.clear ? 160'd0 : acc_reg)
                               + 160'(term_lo_reg) + (160'(pp) <<< 32);
            end
            OP_DET_DONE: adet_reg <= an;
            OP_CMP_MUL:
            begin
                if (cmd.clear)
                    rhs_reg <= 192'(rp);
                else
                    rhs_reg <= rhs_reg + (192'(rp) << (32 * limb));
            end
            default: ;
        endcase
    end

    assign stat.broad_miss = broad_miss_reg;
    assign stat.singular   = singular_reg;
    assign stat.cmp_miss   = cmp_miss_reg;

endmodule

// ===== sv/obphs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Oriented box point hit scan controller
// Decodes commands, walks the boxes and sequences datapath micro-operations.
// ----------------------------------------------------------------------------
module obphs_ctrl
    import obphs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [3:0]         box_index,
    input  logic [4:0]         word_index,
    input  logic               enable_value,
    input  logic [4:0]         box_count_q,
    output logic               wr_en,
    output logic [AddrW-1:0]   wr_addr,
    output logic               pt_load,
    output logic [BoxW-1:0]    rd_box,
    output dp_cmd_t            dcmd,
    input  dp_stat_t           stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [3:0]         hit_index
);

    state_t               state_reg, state_next;
    logic [MaxBoxes-1:0]  en_reg, en_next;
    logic [CountW-1:0]    box_reg, box_next;
    logic [CountW-1:0]    lim_reg, lim_next;
    logic [4:0]           step_reg, step_next;
    logic [1:0]           row_reg, row_next;
    logic                 hit_reg, hit_next;
    logic [3:0]           hidx_reg, hidx_next;
    logic                 ov_reg, ov_next;
    logic                 acc;

    assign acc       = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign hit       = hit_reg;
    assign hit_index = hidx_reg;
    assign rd_box    = box_reg[BoxW-1:0];
    assign wr_en     = acc && (command == CMD_LOAD) && (word_index < 5'(BoxWords));
    assign wr_addr   = AddrW'(box_index * BoxWords) + AddrW'(word_index);
    assign pt_load   = acc && (command == CMD_QUERY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            en_reg    <= '1;
            box_reg   <= '0;
            lim_reg   <= '0;
            step_reg  <= '0;
            row_reg   <= '0;
            hit_reg   <= 1'b0;
            hidx_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            en_reg    <= en_next;
            box_reg   <= box_next;
            lim_reg   <= lim_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            hit_reg   <= hit_next;
            hidx_reg  <= hidx_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        en_next    = en_reg;
        box_next   = box_reg;
        lim_next   = lim_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        hit_next   = hit_reg;
        hidx_next  = hidx_reg;
        ov_next    = ov_reg;
        dcmd       = '{op: OP_NOP, word: 5'd0, row: 2'd0, clear: 1'b0};

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (command)
                        CMD_ENABLE: en_next[box_index] = enable_value;
                        CMD_QUERY:
                        begin
                            box_next   = '0;
                            lim_next   = (box_count_q > 5'(MaxBoxes))
                                         ? CountW'(MaxBoxes) : CountW'(box_count_q);
                            hit_next   = 1'b0;
                            hidx_next  = '0;
                            state_next = ST_NEXT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_NEXT:
            begin
                // skip disabled boxes, end of list gives the result
                if (box_reg >= lim_reg)
                    state_next = ST_OUT;
                else if (!en_reg[box_reg[BoxW-1:0]])
                    box_next = box_reg + 1'b1;
                else
                begin
                    step_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // one word a cycle, then wait while the last read passes the read register into the word registers
                if (step_reg < 5'(BoxWords))
                    dcmd = '{op: OP_READ, word: step_reg, row: 2'd0, clear: 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == 5'(BoxWords + 1))
                begin
                    step_next  = '0;
                    state_next = ST_BROAD;
                end
            end
            ST_BROAD:
            begin
                dcmd = '{op: OP_BROAD, word: 5'd0, row: step_reg[1:0],
                         clear: (step_reg == 5'd0)};
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd3)
                begin
                    step_next = '0;
                    if (stat.broad_miss)
                    begin
                        box_next   = box_reg + 1'b1;
                        state_next = ST_NEXT;
                    end
                    else
                        state_next = ST_COF;
                end
                else if (step_reg == 5'd2)
                    dcmd.op = OP_BROAD;
                if (step_reg == 5'd3)
                    dcmd.op = OP_NOP;
            end
            ST_COF:
            begin
                // each cofactor: first product step, then second product and subtract
                dcmd = '{op: step_reg[0] ? OP_MUL_B : OP_MUL_A,
                         word: {1'b0, step_reg[4:1]}, row: 2'd0, clear: 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd17)
                begin
                    step_next  = '0;
                    row_next   = 2'd3;
                    state_next = ST_DET;
                end
            end
            ST_DET, ST_ROW:
            begin
                // three terms, two multiply phases each, then the determinant check or the size compare
                if (step_reg < 5'd6)
                    dcmd = '{op: OP_DOT_MUL, word: {3'd0, step_reg[2:1]},
                             row: row_reg, clear: (step_reg == 5'd1)};
                else if (state_reg == ST_DET)
                    dcmd = '{op: OP_DET_DONE, word: 5'd0, row: 2'd0, clear: 1'b0};
                else if (step_reg < 5'd11)
                    dcmd = '{op: OP_CMP_MUL, word: step_reg - 5'd6,
                             row: row_reg, clear: (step_reg == 5'd6)};
                else
                    dcmd = '{op: OP_CMP_TEST, word: 5'd0, row: row_reg, clear: 1'b0};
                step_next = step_reg + 1'b1;
                if (state_reg == ST_DET && step_reg == 5'd7)
                begin
                    step_next = '0;
                    row_next  = 2'd0;
                    if (stat.singular)
                        state_next = ST_DECIDE;
                    else
                        state_next = ST_ROW;
                end
                if (state_reg == ST_ROW && step_reg == 5'd12)
                begin
                    step_next = '0;
                    if (row_reg == 2'd2)
                        state_next = ST_DECIDE;
                    else
                        row_next = row_reg + 1'b1;
                end
            end
            ST_DECIDE:
            begin
                if (stat.singular || !stat.cmp_miss)
                begin
                    hit_next   = 1'b1;
                    hidx_next  = box_reg[3:0];
                    state_next = ST_OUT;
                end
                else
                begin
                    box_next   = box_reg + 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE)) else $error("ready outside idle");
    a_out_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg) == ST_OUT) else $error("stray result");
    a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !hit_reg) |-> (hidx_reg == 4'd0)) else $error("index without hit");

endmodule

// ===== sv/oriented_box_point_hit_scan_top.sv =====
// Load, enable and ignored commands are taken on acceptance. A query scans the
// enabled boxes: word reads and broad phase, then, for boxes that pass it, cofactors,
// determinant and three adjugate rows through shared multipliers, the rows skipped
// for a near-singular box; the scan stops at the first hit. One transaction at a time.
// Reset clears enables to ones and box_count to 0; box words are not cleared.
// ----------------------------------------------------------------------------
// Oriented box point hit scan top level
// Configuration register, controller and datapath.
// ----------------------------------------------------------------------------
module oriented_box_point_hit_scan_top
    import obphs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [3:0]         box_index,
    input  logic [4:0]         word_index,
    input  logic signed [31:0] word_data,
    input  logic               enable_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [3:0]         hit_index
);

    logic [4:0]         box_count_reg;
    logic               wr_en, pt_load;
    logic [AddrW-1:0]   wr_addr;
    logic [BoxW-1:0]    rd_box;
    dp_cmd_t            dcmd;
    dp_stat_t           stat;

    assign cfg_ready = 1'b1;

    // hold box count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_count_reg <= '0;
        else if (cfg_valid)
            box_count_reg <= cfg_data;
    end

    obphs_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .command, .box_index, .word_index,
        .enable_value, .box_count_q(box_count_reg), .wr_en, .wr_addr, .pt_load,
        .rd_box, .dcmd, .stat, .out_valid, .out_ready, .hit, .hit_index
    );

    obphs_datapath u_dp (
        .clk, .rst_n, .wr_en, .wr_addr, .wr_data(word_data), .rd_box,
        .pt_load, .point_x, .point_y, .point_z, .cmd(dcmd), .stat
    );

endmodule

// ===== tb/hit_scan_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box hit scan checker
// Watches the configuration, command and result channels, keeps its own copy
// of the box table, works out the expected hit for every accepted query and
// compares each returned result against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module hit_scan_checker
    import obphs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         command,
    input  logic [3:0]         box_index,
    input  logic [4:0]         word_index,
    input  logic signed [31:0] word_data,
    input  logic               enable_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               hit,
    input  logic [3:0]         hit_index,
    output int                 failures,
    output int                 pending
);

    typedef logic signed [159:0] wide_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] index;
    } hit_result_t;

    logic signed [31:0] box_table [MaxBoxes][BoxWords];
    logic               box_on [MaxBoxes];
    logic [4:0]         scan_count;
    hit_result_t        hits_due [$];

    initial begin
        failures = 0;
        pending  = 0;
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        failures++;
    endtask

    function automatic longint cofactor(input longint a, input longint b,
                                        input longint c, input longint d);
        return a * b - c * d;
    endfunction

    function automatic wide_t dot3(input longint a0, input longint a1, input longint a2,
                                   input longint b0, input longint b1, input longint b2);
        wide_t x0, x1, x2, y0, y1, y2;
        x0 = a0; x1 = a1; x2 = a2;
        y0 = b0; y1 = b1; y2 = b2;
        return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    // Broad phase, inverse transform by adjugate, then half-size compare
    function automatic bit box_holds(input int b, input longint px, input longint py,
                                     input longint pz);
        longint p [3];
        longint m [9];
        longint k [9];
        longint v [3];
        longint mn, lim, d, s;
        wide_t  det, adet, acc, lhs, rhs, ws;
        p[0] = px; p[1] = py; p[2] = pz;
        mn = box_table[b][12];
        if (box_table[b][13] < mn) mn = box_table[b][13];
        if (box_table[b][14] < mn) mn = box_table[b][14];
        lim = 2 * mn;
        for (int i = 0; i < 3; i++)
        begin
            d = p[i] - longint'(box_table[b][15 + i]);
            if (d < 0) d = -d;
            if (d > lim) return 1'b0;
        end
        for (int i = 0; i < 9; i++)
            m[i] = box_table[b][i];
        k[0] = cofactor(m[4], m[8], m[5], m[7]);
        k[1] = cofactor(m[2], m[7], m[1], m[8]);
        k[2] = cofactor(m[1], m[5], m[2], m[4]);
        k[3] = cofactor(m[5], m[6], m[3], m[8]);
        k[4] = cofactor(m[0], m[8], m[2], m[6]);
        k[5] = cofactor(m[2], m[3], m[0], m[5]);
        k[6] = cofactor(m[3], m[7], m[4], m[6]);
        k[7] = cofactor(m[1], m[6], m[0], m[7]);
        k[8] = cofactor(m[0], m[4], m[1], m[3]);
        det  = dot3(m[0], m[1], m[2], k[0], k[3], k[6]);
        adet = (det < 0) ? -det : det;
        // near-singular: the point maps to the origin and always passes
        if (adet <= wide_t'(DetEps)) return 1'b1;
        for (int i = 0; i < 3; i++)
            v[i] = p[i] - longint'(box_table[b][9 + i]);
        for (int i = 0; i < 3; i++)
        begin
            s = box_table[b][12 + i];
            if (s < 0) s = -s;
            ws  = s;
            acc = dot3(k[3 * i], k[3 * i + 1], k[3 * i + 2], v[0], v[1], v[2]);
            if (acc < 0) acc = -acc;
            lhs = acc <<< 17;
            rhs = ws * adet;
            if (lhs > rhs) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic hit_result_t first_hit(input longint px, input longint py,
                                              input longint pz);
        hit_result_t r;
        int          n;
        r = '0;
        n = (scan_count > MaxBoxes) ? MaxBoxes : scan_count;
        for (int i = 0; i < n; i++)
        begin
            if (box_on[i] && box_holds(i, px, py, pz))
            begin
                r.hit   = 1'b1;
                r.index = i[3:0];
                return r;
            end
        end
        return r;
    endfunction

    // Compare results, then apply configuration and command transactions
    always @(posedge clk or negedge rst_n)
    begin
        hit_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MaxBoxes; i++)
                box_on[i] = 1'b1;
            scan_count = '0;
            hits_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (hits_due.size() == 0)
                    flag_mismatch($sformatf("unexpected result hit=%0b index=%0d",
                                            hit, hit_index));
                else
                begin
                    want = hits_due.pop_front();
                    if (hit !== want.hit)
                        flag_mismatch($sformatf("hit got %0b want %0b", hit, want.hit));
                    if (hit_index !== want.index)
                        flag_mismatch($sformatf("hit_index got %0d want %0d",
                                                hit_index, want.index));
                end
            end
            if (cfg_valid && cfg_ready)
                scan_count = cfg_data;
            if (in_valid && in_ready)
            begin
                case (cmd_t'(command))
                    CMD_LOAD:
                        if (word_index < BoxWords)
                            box_table[box_index][word_index] = word_data;
                    CMD_ENABLE:
                        box_on[box_index] = enable_value;
                    CMD_QUERY:
                        hits_due = {hits_due, first_hit(point_x, point_y, point_z)};
                    default: ;
                endcase
            end
        end
        pending = hits_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box hit scan testbench
// Loads a table of oriented boxes, then drives directed and random commands
// with random idle bursts on both channels; the checker does the comparison.
// ----------------------------------------------------------------------------
module testbench;
    import obphs_pkg::*;

    localparam int CycleLimit = 8000000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [4:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic [3:0]         box_index;
    logic [4:0]         word_index;
    logic signed [31:0] word_data;
    logic               enable_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               out_valid;
    logic               out_ready;
    logic               hit;
    logic [3:0]         hit_index;
    int                 failures;
    int                 pending;
    int                 cycles;
    bit                 calm;
    int                 stall_left;

    // box words as written, used to aim query points and to build consistent box words
    logic signed [31:0] shadow [MaxBoxes][BoxWords];

    oriented_box_point_hit_scan_top dut (.*);

    hit_scan_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stall bursts until the calm part
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic logic signed [31:0] signed_range(input int lo, input int hi);
        int mag;
        mag = $urandom_range(hi, lo);
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    // Well-formed value for one box word, consistent with the rest of the box
    function automatic logic signed [31:0] sane_word(input int b, input int w);
        if (w == 0 || w == 4 || w == 8) return signed_range(32768, 131072);
        if (w < 9)                      return signed_range(0, 32768);
        if (w < 12)                     return shadow[b][w + 6] + signed_range(0, 8192);
        if (w < 15)                     return $urandom_range(65536, 524288);
        return shadow[b][w - 6] + signed_range(0, 8192);
    endfunction

    task automatic send_item(input cmd_t cmd, input logic [3:0] bi, input logic [4:0] wi,
                             input logic signed [31:0] data, input logic en,
                             input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] pz);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        command      = cmd;
        box_index    = bi;
        word_index   = wi;
        word_data    = data;
        enable_value = en;
        point_x      = px;
        point_y      = py;
        point_z      = pz;
        in_valid     = 1'b1;
        do @(posedge clk); while (!in_ready);
        if (cmd == CMD_LOAD && wi < BoxWords)
            shadow[bi][wi] = data;
    endtask

    task automatic load_word(input int b, input int w, input logic signed [31:0] data);
        send_item(CMD_LOAD, 4'(b), 5'(w), data, 1'($urandom), $urandom, $urandom,
                  $urandom);
    endtask

    task automatic set_enable(input int b, input logic en);
        send_item(CMD_ENABLE, 4'(b), 5'($urandom), $urandom, en, $urandom, $urandom,
                  $urandom);
    endtask

    task automatic query(input logic signed [31:0] px, input logic signed [31:0] py,
                         input logic signed [31:0] pz);
        send_item(CMD_QUERY, 4'($urandom), 5'($urandom), $urandom, 1'($urandom),
                  px, py, pz);
    endtask

    // Aim at a box: mostly within its sizes around the centre
    task automatic query_near(input int b);
        int reach;
        reach = $urandom_range(16384, 393216);
        query(shadow[b][15] + signed_range(0, reach), shadow[b][16] + signed_range(0, reach),
              shadow[b][17] + signed_range(0, reach));
    endtask

    // kind: 0 well-formed, 1 singular, 2 negative size, 3 raw random
    task automatic load_box(input int b, input int kind);
        logic signed [31:0] centre [3];
        for (int i = 0; i < 3; i++)
            centre[i] = signed_range(0, 16777216);
        for (int w = 0; w < BoxWords; w++)
        begin
            if (kind == 3)
                load_word(b, w, $urandom);
            else if (w >= 15)
                load_word(b, w, centre[w - 15]);
            else if (w >= 9 && w < 12)
                load_word(b, w, centre[w - 9] + signed_range(0, 8192));
            else if (kind == 1 && w < 9)
                load_word(b, w, '0);
            else if (kind == 2 && w == 13)
                load_word(b, w, -$urandom_range(1, 65536));
            else
                load_word(b, w, sane_word(b, w));
        end
    endtask

    // Hold until nothing is outstanding and the last command has settled
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_count(input logic [4:0] value);
        settle();
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_item();
        int r, b;
        r = $urandom_range(0, 99);
        b = $urandom_range(0, MaxBoxes - 1);
        if (r < 40)
            query_near(b);
        else if (r < 48)
            query($urandom, $urandom, $urandom);
        else if (r < 52)
            load_box(b, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        else if (r < 70)
            load_word(b, $urandom_range(0, 17), ($urandom_range(0, 4) == 0) ? $urandom
                      : sane_word(b, $urandom_range(0, 17)));
        else if (r < 84)
            set_enable(b, $urandom_range(0, 3) != 0);
        else if (r < 92)
            send_item(CMD_NONE, 4'($urandom), 5'($urandom), $urandom, 1'($urandom),
                      $urandom, $urandom, $urandom);
        else
            send_item(CMD_LOAD, 4'($urandom), 5'($urandom_range(18, 31)), $urandom,
                      1'($urandom), $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        logic [4:0] counts [5];
        cycles       = 0;
        calm         = 1'b0;
        stall_left   = 0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        command      = CMD_NONE;
        box_index    = '0;
        word_index   = '0;
        word_data    = '0;
        enable_value = 1'b0;
        point_x      = '0;
        point_y      = '0;
        point_z      = '0;
        out_ready    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill the whole table before any box is scanned
        for (int b = 0; b < MaxBoxes; b++)
            load_box(b, (b == 2) ? 1 : (b == 3) ? 2 : (b == 14) ? 3 : 0);

        // Directed: extremes, each command, singular and negative-size boxes
        write_count(5'd16);
        query(shadow[0][15], shadow[0][16], shadow[0][17]);
        query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        query(32'sh80000000, 32'sh80000000, 32'sh80000000);
        set_enable(0, 1'b0);
        query_near(0);
        set_enable(0, 1'b1);
        set_enable(1, 1'b0);
        query(shadow[2][15], shadow[2][16], shadow[2][17]);
        query(shadow[3][15], shadow[3][16], shadow[3][17]);
        load_word(15, 0, 32'sh80000000);
        load_word(15, 4, 32'sh7fffffff);
        query_near(15);
        send_item(CMD_LOAD, 4'hf, 5'd31, 32'sh7fffffff, 1'b1, 0, 0, 0);
        send_item(CMD_NONE, 4'hf, 5'd31, '1, 1'b1, '1, '1, '1);
        set_enable(1, 1'b1);
        write_count(5'd31);
        query_near(15);
        write_count(5'd0);
        query_near(0);
        write_count(5'd17);
        query_near(1);

        // Random phases over several scan counts; the last runs without idling
        counts = '{5'd16, 5'd1, 5'd31, 5'($urandom_range(0, 31)), 5'd16};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_count(counts[ph]);
            if (ph == 4) calm = 1'b1;
            for (int n = 0; n < 55; n++)
                random_item();
        end

        settle();
        repeat (30) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/obphs_pkg.sv
sv/obphs_datapath.sv
sv/obphs_ctrl.sv
sv/oriented_box_point_hit_scan_top.sv
tb/hit_scan_checker.sv
tb/testbench.sv
